// File: hw/rtl/bsfr_pkg.sv
// Shared types and constants for the byte-stuffed frame receiver.
`timescale 1ns / 1ps

package bsfr_pkg;

    localparam logic [7:0] START_CODE = 8'h56;
    localparam logic [7:0] END_CODE   = 8'h9E;
    localparam logic [7:0] ESC_CODE   = 8'hCC;
    localparam logic [7:0] ESC_START  = ~START_CODE;
    localparam logic [7:0] ESC_END    = ~END_CODE;
    localparam logic [7:0] ESC_ESC    = ~ESC_CODE;

    localparam int unsigned MIN_DECODED = 3;
    localparam int unsigned LEN_W       = 10;
    localparam int unsigned TICK_W      = 16;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd1000;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_LINE  = 2'd2,
        CMD_TICK  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_OVERFLOW = 3'd2,
        ST_BADESC   = 3'd3,
        ST_LINE     = 3'd4,
        ST_TIMEOUT  = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_HUNT  = 3'b010,
        PH_FRAME = 3'b100
    } phase_t;

    // One classified transaction as it travels from front to back.
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data;
        logic       is_start;
        logic       is_end;
        logic       is_esc;
        logic       esc_ok;
        logic [7:0] esc_val;
    } item_t;

    // Register addresses on the configuration port (word index bit).
    localparam logic REG_TIMEOUT = 1'b0;

endpackage

// File: hw/rtl/byte_stuffed_frame_receiver.sv
// Top level of the byte-stuffed frame receiver: front, queue, back and register.
//
//  channel  direction  handshake            payload
//  in       in         in_valid / in_stall  cmd, rx_byte
//  out      out        out_valid/out_stall  payload_byte, is_report, frame_status,
//                                           payload_length, check_field
//  cfg      in         APB write/read       timeout_ticks at byte address 0
//
// One transaction per cycle sustained while out_stall is low; each input is
// held in the queue register and its result in the output register. The back-end
// state machine handles each queued transaction as it pops it. The queue absorbs
// input while the output register is stalled; in_stall rises only when the queue
// is full. rst_n clears all control state and loads timeout_ticks with 1000.
`timescale 1ns / 1ps

module byte_stuffed_frame_receiver
    import bsfr_pkg::*;
#(
    parameter int unsigned MAX_FRAME   = 1024,
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        cmd,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        payload_byte,
    output logic              is_report,
    output logic [2:0]        frame_status,
    output logic [LEN_W-1:0]  payload_length,
    output logic [15:0]       check_field,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic              q_full;
    logic              q_push;
    item_t             q_item;
    logic              q_pop;
    logic              q_not_empty;
    item_t             q_head;
    logic [TICK_W-1:0] timeout_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TIMEOUT) ? {16'b0, timeout_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_TIMEOUT)
        begin
            timeout_reg <= pwdata[TICK_W-1:0];
        end
    end

    bsfr_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .rx_byte  (rx_byte),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_item)
    );

    bsfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    bsfr_back #(
        .MAX_FRAME (MAX_FRAME)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_not_empty    (q_not_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .timeout_ticks  (timeout_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .payload_byte   (payload_byte),
        .is_report      (is_report),
        .frame_status   (frame_status),
        .payload_length (payload_length),
        .check_field    (check_field)
    );

endmodule

// File: hw/rtl/bsfr_front.sv
// Front end: accepts input transactions and classifies line bytes.
`timescale 1ns / 1ps

module bsfr_front
    import bsfr_pkg::*;
(
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] cmd,
    input  logic [7:0] rx_byte,
    input  logic       q_full,
    output logic       q_push,
    output item_t      q_item
);

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_item          = '0;
        q_item.cmd      = cmd_t'(cmd);
        q_item.data     = rx_byte;
        q_item.is_start = (rx_byte == START_CODE);
        q_item.is_end   = (rx_byte == END_CODE);
        q_item.is_esc   = (rx_byte == ESC_CODE);
        // decode the byte that would follow an escape
        q_item.esc_ok   = 1'b1;
        q_item.esc_val  = rx_byte;
        unique case (rx_byte)
            ESC_START: q_item.esc_val = START_CODE;
            ESC_END:   q_item.esc_val = END_CODE;
            ESC_ESC:   q_item.esc_val = ESC_CODE;
            default:   q_item.esc_ok  = 1'b0;
        endcase
    end

endmodule

// File: hw/rtl/bsfr_queue.sv
// Short FIFO of classified transactions between front and back.
`timescale 1ns / 1ps

module bsfr_queue
    import bsfr_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output item_t head
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    item_t           entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   fill_reg, fill_next;

    assign full      = (fill_reg == CW'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: hw/rtl/bsfr_back.sv
// Back end: frame state machine, unescaping, byte delay and result register.
`timescale 1ns / 1ps

module bsfr_back
    import bsfr_pkg::*;
#(
    parameter int unsigned MAX_FRAME = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_not_empty,
    input  item_t             q_head,
    output logic              q_pop,
    input  logic [TICK_W-1:0] timeout_ticks,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        payload_byte,
    output logic              is_report,
    output logic [2:0]        frame_status,
    output logic [LEN_W-1:0]  payload_length,
    output logic [15:0]       check_field
);

    localparam int unsigned CW = $clog2(MAX_FRAME);

    phase_t             phase_reg, phase_next;
    logic               esc_reg, esc_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [7:0]         older_reg, older_next;
    logic [7:0]         newer_reg, newer_next;
    logic [TICK_W-1:0]  ticks_reg, ticks_next;

    logic               out_valid_reg;
    logic [7:0]         byte_reg;
    logic               report_reg;
    status_t            status_reg;
    logic [LEN_W-1:0]   length_reg;
    logic [15:0]        check_reg;

    logic               emit;
    logic               rep;
    status_t            rep_status;
    logic [LEN_W-1:0]   rep_len;
    logic [15:0]        rep_check;
    logic [7:0]         emit_byte;
    logic               do_accept;
    logic [7:0]         acc_byte;
    logic [CW:0]        count_inc;
    logic [CW-1:0]      len_raw;
    logic [CW+LEN_W-1:0] len_wide;

    assign q_pop     = q_not_empty && (!out_valid_reg || !out_stall);
    assign count_inc = {1'b0, count_reg} + 1'b1;
    assign len_raw   = count_reg - CW'(2);
    assign len_wide  = {{LEN_W{1'b0}}, len_raw};

    always_comb
    begin
        phase_next = phase_reg;
        esc_next   = esc_reg;
        count_next = count_reg;
        older_next = older_reg;
        newer_next = newer_reg;
        ticks_next = ticks_reg;
        emit       = 1'b0;
        rep        = 1'b0;
        rep_status = ST_OK;
        rep_len    = '0;
        rep_check  = '0;
        emit_byte  = '0;
        do_accept  = 1'b0;
        acc_byte   = q_head.data;

        unique case (q_head.cmd)
            CMD_START:
            begin
                phase_next = PH_HUNT;
                esc_next   = 1'b0;
                count_next = '0;
                older_next = '0;
                newer_next = '0;
                ticks_next = timeout_ticks;
            end
            CMD_BYTE:
            begin
                if (phase_reg == PH_HUNT)
                begin
                    if (q_head.is_start)
                    begin
                        phase_next = PH_FRAME;
                        esc_next   = 1'b0;
                        count_next = '0;
                        older_next = '0;
                        newer_next = '0;
                    end
                end
                else if (phase_reg == PH_FRAME)
                begin
                    if (q_head.is_end)
                    begin
                        // an end code closes the frame even right after an escape
                        rep = 1'b1;
                        if (count_reg < CW'(MIN_DECODED))
                        begin
                            rep_status = ST_SHORT;
                        end
                        else
                        begin
                            rep_len   = len_wide[LEN_W-1:0];
                            rep_check = {newer_reg, older_reg};
                        end
                    end
                    else if (esc_reg)
                    begin
                        esc_next = 1'b0;
                        if (q_head.esc_ok)
                        begin
                            do_accept = 1'b1;
                            acc_byte  = q_head.esc_val;
                        end
                        else
                        begin
                            rep        = 1'b1;
                            rep_status = ST_BADESC;
                        end
                    end
                    else if (q_head.is_esc)
                    begin
                        esc_next = 1'b1;
                    end
                    else
                    begin
                        do_accept = 1'b1;
                    end
                end
            end
            CMD_LINE:
            begin
                if (phase_reg == PH_FRAME)
                begin
                    rep        = 1'b1;
                    rep_status = ST_LINE;
                end
            end
            CMD_TICK:
            begin
                if (phase_reg == PH_HUNT || phase_reg == PH_FRAME)
                begin
                    if (ticks_reg <= TICK_W'(1))
                    begin
                        ticks_next = '0;
                        rep        = 1'b1;
                        rep_status = ST_TIMEOUT;
                    end
                    else
                    begin
                        ticks_next = ticks_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        // shift the decoded byte through the two-byte hold
        if (do_accept)
        begin
            older_next = newer_reg;
            newer_next = acc_byte;
            count_next = count_inc[CW-1:0];
            if (count_inc >= (CW+1)'(MAX_FRAME))
            begin
                rep        = 1'b1;
                rep_status = ST_OVERFLOW;
            end
            else if (count_inc > (CW+1)'(2))
            begin
                emit      = 1'b1;
                emit_byte = older_reg;
            end
        end

        if (rep)
        begin
            emit       = 1'b1;
            emit_byte  = '0;
            phase_next = PH_IDLE;
            esc_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            esc_reg       <= 1'b0;
            count_reg     <= '0;
            older_reg     <= '0;
            newer_reg     <= '0;
            ticks_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg <= phase_next;
                esc_reg   <= esc_next;
                count_reg <= count_next;
                older_reg <= older_next;
                newer_reg <= newer_next;
                ticks_reg <= ticks_next;
            end
            if (q_pop && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && emit)
        begin
            byte_reg   <= emit_byte;
            report_reg <= rep;
            status_reg <= rep_status;
            length_reg <= rep_len;
            check_reg  <= rep_check;
        end
    end

    assign out_valid      = out_valid_reg;
    assign payload_byte   = byte_reg;
    assign is_report      = report_reg;
    assign frame_status   = status_reg;
    assign payload_length = length_reg;
    assign check_field    = check_reg;

    a_report_ends_attempt: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && rep |=> phase_reg == PH_IDLE && !esc_reg)
        else $error("report did not return the receiver to idle");

    a_escape_only_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg |-> phase_reg == PH_FRAME)
        else $error("escape pending outside a frame");

    a_payload_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !report_reg |->
            status_reg == ST_OK && length_reg == '0 && check_reg == '0)
        else $error("payload result carries report fields");

    a_error_report_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && report_reg && status_reg != ST_OK |->
            byte_reg == '0 && length_reg == '0 && check_reg == '0)
        else $error("error report carries length or check field");

    a_payload_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && emit && !rep |-> phase_reg == PH_FRAME)
        else $error("payload byte emitted outside a frame");

endmodule
